// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is active.
`define HSEV_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Clocked assertion that is also checked while the reset is active.
`define HSEV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/core/hsev_pkg.sv =====
// Shared types and constants of the 3D Hermite spline evaluator.
// Used by the lane, merge, top-level and checker files and the testbench; depends on nothing.
`default_nettype none
package hsev_pkg;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_POS  = 2'd1;
	localparam logic [1:0] ACT_DER  = 2'd2;

	// Tangent selection. For the start tangent: FWD is 2(p2-p1), BWD is 2(p1-pm),
	// CEN is p2-pm. For the end tangent: FWD is 2(p2-p1), CEN is p3-p1.
	localparam logic [1:0] TAN_ZERO = 2'd0;
	localparam logic [1:0] TAN_FWD  = 2'd1;
	localparam logic [1:0] TAN_BWD  = 2'd2;
	localparam logic [1:0] TAN_CEN  = 2'd3;

	localparam int CW = 42;
	localparam int TW = 17;
	localparam logic [TW-1:0] T_ONE = 17'd65536;

	typedef struct packed {
		logic       cap_en;
		logic [1:0] cap_slot;
		logic       tan_en;
		logic [1:0] r1_sel;
		logic [1:0] r2_sel;
		logic       last;
		logic       coef_en;
		logic       deriv;
		logic       mul_en;
		logic       add_en;
		logic [1:0] step;
	} lane_cmd_t;

	typedef struct packed {
		logic [31:0] value;
		logic        clip;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/hsev_lane.sv =====
// One axis lane: captures four neighbouring points, forms the doubled
// Hermite coefficients and runs Horner's scheme. Depends on hsev_pkg.
`default_nettype none
module hsev_lane (
	input  wire                        clk,
	input  wire hsev_pkg::lane_cmd_t   cmd,
	input  wire signed [31:0]          rd_coord,
	input  wire [hsev_pkg::TW-1:0]     t,
	output hsev_pkg::lane_res_t        res
);
	localparam int CW = hsev_pkg::CW;
	localparam int PW = CW + 18;

	logic signed [31:0]   pm_q, p1_q, p2_q, p3_q;
	logic signed [CW-1:0] r1_q, r2_q, e1_q, e2_q;
	logic signed [CW-1:0] m0_q, add1_q, c_q, d_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CW-1:0] acc_q;

	logic signed [CW-1:0] xm, x1, x2, x3, r1, r2;
	logic signed [CW-1:0] ca, cb, op, addend, hv;
	logic signed [PW-1:0] rsum, rsh;

	always_comb begin
		xm = CW'(pm_q);
		x1 = CW'(p1_q);
		x2 = CW'(p2_q);
		x3 = CW'(p3_q);
		case (cmd.r1_sel)
			hsev_pkg::TAN_FWD: r1 = (x2 - x1) <<< 1;
			hsev_pkg::TAN_BWD: r1 = (x1 - xm) <<< 1;
			hsev_pkg::TAN_CEN: r1 = x2 - xm;
			default:           r1 = '0;
		endcase
		if (cmd.last) begin
			r2 = r1;
		end else begin
			case (cmd.r2_sel)
				hsev_pkg::TAN_FWD: r2 = (x2 - x1) <<< 1;
				hsev_pkg::TAN_CEN: r2 = x3 - x1;
				default:           r2 = '0;
			endcase
		end
		ca = ((e1_q - e2_q) <<< 2) + r1_q + r2_q;
		cb = ((e2_q - e1_q) <<< 2) + ((e2_q - e1_q) <<< 1) - (r1_q <<< 1) - r2_q;
		op = (cmd.step == 2'd1) ? m0_q : acc_q;
		case (cmd.step)
			2'd1:    addend = add1_q;
			2'd2:    addend = c_q;
			default: addend = d_q;
		endcase
		rsum = prod_q + PW'(32768);
		rsh  = rsum >>> 16;
		hv   = (acc_q + CW'(1)) >>> 1;
		res.clip  = (hv[CW-1:31] != {(CW-31){hv[31]}});
		res.value = res.clip ? (hv[CW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : hv[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_slot)
				2'd0:    pm_q <= rd_coord;
				2'd1:    p1_q <= rd_coord;
				2'd2:    p2_q <= rd_coord;
				default: p3_q <= rd_coord;
			endcase
		end
		if (cmd.tan_en) begin
			r1_q <= r1;
			r2_q <= r2;
			e1_q <= x1;
			e2_q <= cmd.last ? x1 : x2;
		end
		if (cmd.coef_en) begin
			m0_q   <= cmd.deriv ? (ca + (ca <<< 1)) : ca;
			add1_q <= cmd.deriv ? (cb <<< 1) : cb;
			c_q    <= r1_q;
			d_q    <= e1_q <<< 1;
		end
		if (cmd.mul_en) begin
			prod_q <= op * $signed({1'b0, t});
		end
		if (cmd.add_en) begin
			acc_q <= rsh[CW-1:0] + addend;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/hsev_merge.sv =====
// Merging stage: combines the three lane results into one registered result
// with status and clip flag, and holds it until taken. Depends on hsev_pkg.
`default_nettype none
module hsev_merge (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load_en,
	input  wire                  oor,
	input  wire hsev_pkg::lane_res_t res_x,
	input  wire hsev_pkg::lane_res_t res_y,
	input  wire hsev_pkg::lane_res_t res_z,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [31:0]   out_z,
	output logic                 status,
	output logic                 clipped
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_en) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			out_x   <= oor ? 32'sd0 : res_x.value;
			out_y   <= oor ? 32'sd0 : res_y.value;
			out_z   <= oor ? 32'sd0 : res_z.value;
			status  <= oor;
			clipped <= !oor && (res_x.clip || res_y.clip || res_z.clip);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/hermite_spline_eval_3d_top.sv =====
// Catmull-Rom spline evaluator over up to MAX_POINTS 3D points in Q16.16. A load request
// writes one point of the store. An evaluate request reads four neighbouring points over
// the single read port of the point store, forms tangents and then coefficients, then runs
// each Horner step as a multiply and an add in the three axis lanes, and ends in the merge,
// which waits while an earlier result is still held at the output. An out-of-range segment
// skips the reads and goes straight to the merge. A new request is taken while a result
// still waits at the output.
`default_nettype none
module hermite_spline_eval_3d_top #(
	parameter int MAX_POINTS = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [6:0]          cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire [1:0]          action,
	input  wire [5:0]          point_index,
	input  wire signed [31:0]  coord_x,
	input  wire signed [31:0]  coord_y,
	input  wire signed [31:0]  coord_z,
	input  wire [16:0]         param_t,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               status,
	output logic               clipped
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_TAN  = 3'd3;
	localparam logic [2:0] S_COEF = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_ADD  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]  state_q;
	logic [1:0]  rd_cnt_q, step_q, cap_slot_q;
	logic        cap_en_q;
	logic [6:0]  cnt_q;
	logic [5:0]  idx_q;
	logic [16:0] t_q;
	logic        deriv_q, last_q, oor_q;
	logic [1:0]  r1_sel_q, r2_sel_q;

	logic [95:0]   mem [MAX_POINTS];
	logic [95:0]   rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    addr8;

	logic [6:0] n, idx7;
	logic       is_eval, fin_go;
	logic [1:0] r1_sel, r2_sel;
	hsev_pkg::lane_cmd_t cmd;
	hsev_pkg::lane_res_t res_x, res_y, res_z;

	assign in_ready = (state_q == S_IDLE);
	assign is_eval  = (action == hsev_pkg::ACT_POS) || (action == hsev_pkg::ACT_DER);
	assign fin_go   = (state_q == S_FIN) && (!out_valid || out_ready);

	always_comb begin
		n    = (32'(cnt_q) > MAX_POINTS) ? 7'(MAX_POINTS) : cnt_q;
		idx7 = {1'b0, point_index};
		if (n < 7'd4) begin
			r1_sel = hsev_pkg::TAN_ZERO;
			r2_sel = hsev_pkg::TAN_ZERO;
		end else begin
			if (idx7 == 7'd0)
				r1_sel = hsev_pkg::TAN_FWD;
			else if (idx7 + 7'd1 == n)
				r1_sel = hsev_pkg::TAN_BWD;
			else
				r1_sel = hsev_pkg::TAN_CEN;
			r2_sel = (idx7 + 7'd2 == n) ? hsev_pkg::TAN_FWD : hsev_pkg::TAN_CEN;
		end
		// Slot order is previous point, start, end, next; off-store addresses fold to 0.
		addr8   = {2'b00, idx_q} + {6'd0, rd_cnt_q} - 8'd1;
		rd_addr = (32'(addr8) < MAX_POINTS) ? AW'(addr8) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_cnt_q   <= '0;
			step_q     <= '0;
			cap_en_q   <= 1'b0;
			cap_slot_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we)
				cnt_q <= cfg_data;
			cap_en_q   <= (state_q == S_RD);
			cap_slot_q <= rd_cnt_q;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && is_eval) begin
						rd_cnt_q <= '0;
						step_q   <= 2'd1;
						state_q  <= (idx7 >= n) ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3)
						state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_TAN;
				S_TAN:  state_q <= S_COEF;
				S_COEF: state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD: begin
					if (step_q == (deriv_q ? 2'd2 : 2'd3)) begin
						state_q <= S_FIN;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (fin_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_q    <= point_index;
			t_q      <= (param_t > hsev_pkg::T_ONE) ? hsev_pkg::T_ONE : param_t;
			deriv_q  <= (action == hsev_pkg::ACT_DER);
			oor_q    <= (idx7 >= n);
			last_q   <= (idx7 + 7'd1 >= n);
			r1_sel_q <= r1_sel;
			r2_sel_q <= r2_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && action == hsev_pkg::ACT_LOAD
				&& 32'(point_index) < MAX_POINTS)
			mem[AW'(point_index)] <= {coord_z, coord_y, coord_x};
		if (state_q == S_RD)
			rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		cmd.cap_en   = cap_en_q;
		cmd.cap_slot = cap_slot_q;
		cmd.tan_en   = (state_q == S_TAN);
		cmd.r1_sel   = r1_sel_q;
		cmd.r2_sel   = r2_sel_q;
		cmd.last     = last_q;
		cmd.coef_en  = (state_q == S_COEF);
		cmd.deriv    = deriv_q;
		cmd.mul_en   = (state_q == S_MUL);
		cmd.add_en   = (state_q == S_ADD);
		cmd.step     = step_q;
	end

	hsev_lane u_lane_x (.clk(clk), .cmd(cmd), .rd_coord(rd_data_q[31:0]),  .t(t_q), .res(res_x));
	hsev_lane u_lane_y (.clk(clk), .cmd(cmd), .rd_coord(rd_data_q[63:32]), .t(t_q), .res(res_y));
	hsev_lane u_lane_z (.clk(clk), .cmd(cmd), .rd_coord(rd_data_q[95:64]), .t(t_q), .res(res_z));

	hsev_merge u_merge (
		.clk(clk), .arst_n(arst_n), .load_en(fin_go), .oor(oor_q),
		.res_x(res_x), .res_y(res_y), .res_z(res_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.status(status), .clipped(clipped)
	);
endmodule
`default_nettype wire

// ===== rtl/core/hsev_checker.sv =====
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on assert_macros.svh and hsev_pkg.
`default_nettype none
`include "assert_macros.svh"
module hsev_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire [1:0]  action,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] out_x,
	input wire [31:0] out_y,
	input wire [31:0] out_z,
	input wire        status,
	input wire        clipped
);
	logic eval_req;

	assign eval_req = in_valid && in_ready
		&& (action == hsev_pkg::ACT_POS || action == hsev_pkg::ACT_DER);

	// An evaluate request keeps the block busy for at least the next cycle.
	`HSEV_ASSERT(a_eval_busy, clk, arst_n, eval_req |=> !in_ready)
	// An out-of-range result carries zero coordinates and no clip flag.
	`HSEV_ASSERT(a_oor_zero, clk, arst_n, out_valid && status |-> (out_x | out_y | out_z) == 32'd0 && !clipped)
	// A waiting result is held.
	`HSEV_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(status))
	// While the reset is active no result is shown.
	`HSEV_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid)
endmodule

bind hermite_spline_eval_3d_top hsev_checker u_hsev_checker (.*);
`default_nettype wire

// ===== tb/hermite_spline_eval_3d_top_test.sv =====
// Self-checking testbench for the 3D Catmull-Rom spline evaluator.
// Depends on hsev_pkg and hermite_spline_eval_3d_top; predicts every result in-line.
`timescale 1ns / 1ps
`default_nettype none
module hermite_spline_eval_3d_top_test;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int NPTS = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 30;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        st;
		logic        clip;
	} spline_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = hsev_pkg::ACT_LOAD;
	logic [5:0] point_index = '0;
	logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [16:0] param_t = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic status, clipped;

	longint points [NPTS][3];
	int unsigned point_count_m;
	spline_res_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	hermite_spline_eval_3d_top #(.MAX_POINTS(NPTS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
		.coord_z(coord_z), .param_t(param_t), .out_valid(out_valid),
		.out_ready(out_ready), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.status(status), .clipped(clipped)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// floor((v + 2^(s-1)) / 2^s)
	function automatic longint round_down_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Doubled tangent at point k on one axis.
	function automatic longint doubled_tangent(int k, int n, int c);
		if (n < 4)
			return 0;
		if (k == 0)
			return 2 * (points[1][c] - points[0][c]);
		if (k == n - 1)
			return 2 * (points[n-1][c] - points[n-2][c]);
		return points[k+1][c] - points[k-1][c];
	endfunction

	function automatic spline_res_t spline_eval(logic [1:0] act, int seg, int tin);
		spline_res_t r;
		int n, k2;
		longint t, p1, p2, r1, r2, ca, cb, q;
		logic [31:0] v [3];
		n = (point_count_m > NPTS) ? NPTS : point_count_m;
		r = '{x: '0, y: '0, z: '0, st: 1'b0, clip: 1'b0};
		if (seg >= n) begin
			r.st = 1'b1;
			return r;
		end
		t = (tin > 65536) ? 65536 : tin;
		k2 = (seg + 1 < n) ? seg + 1 : seg;
		for (int c = 0; c < 3; c++) begin
			p1 = points[seg][c];
			p2 = points[k2][c];
			r1 = doubled_tangent(seg, n, c);
			r2 = doubled_tangent(k2, n, c);
			ca = 4 * p1 - 4 * p2 + r1 + r2;
			cb = -6 * p1 + 6 * p2 - 2 * r1 - r2;
			if (act == hsev_pkg::ACT_POS) begin
				q = round_down_shift(ca * t, 16) + cb;
				q = round_down_shift(q * t, 16) + r1;
				q = round_down_shift(q * t, 16) + 2 * p1;
			end else begin
				q = round_down_shift(3 * ca * t, 16) + 2 * cb;
				q = round_down_shift(q * t, 16) + r1;
			end
			q = round_down_shift(q, 1);
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
				r.clip = 1'b1;
			end else if (q < -64'sd2147483648) begin
				q = -64'sd2147483648;
				r.clip = 1'b1;
			end
			v[c] = q[31:0];
		end
		r.x = v[0];
		r.y = v[1];
		r.z = v[2];
		return r;
	endfunction

	// Receiver: random stalls, or a long counted hold-off when asked for.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		spline_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with none expected: x=%h y=%h z=%h status=%b clipped=%b",
					$time, out_x, out_y, out_z, status, clipped);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_x !== e.x) begin
					$display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
					errors++;
				end
				if (out_y !== e.y) begin
					$display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
					errors++;
				end
				if (out_z !== e.z) begin
					$display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %b actual %b", $time, e.st, status);
					errors++;
				end
				if (clipped !== e.clip) begin
					$display("%0t: clipped expected %b actual %b", $time, e.clip, clipped);
					errors++;
				end
			end
		end
	end

	task automatic send_request(logic [1:0] act, int idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, int t);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		point_index = idx[5:0];
		coord_x = x;
		coord_y = y;
		coord_z = z;
		param_t = t[16:0];
		do
			@(posedge clk);
		while (!in_ready);
		if (act == hsev_pkg::ACT_LOAD) begin
			points[idx][0] = longint'(signed'(x));
			points[idx][1] = longint'(signed'(y));
			points[idx][2] = longint'(signed'(z));
		end else if (act != ACT_NONE) begin
			pending_q = {pending_q, spline_eval(act, idx, t)};
		end
	endtask

	// Lets the block finish everything, including loads that give no result.
	task automatic drain_all;
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_point_count(int value);
		drain_all();
		cfg_we = 1'b1;
		cfg_data = value[6:0];
		@(negedge clk);
		cfg_we = 1'b0;
		point_count_m = value & 7'h7f;
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return 32'h7fffffff;
			3: return 32'h80000000;
			default: return $urandom_range(0, 32'h7fffff) - 32'h400000;
		endcase
	endfunction

	function automatic int random_t();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic random_request(int n);
		int r, seg;
		r = $urandom_range(0, 99);
		if (r < 20)
			send_request(hsev_pkg::ACT_LOAD, $urandom_range(0, 63), random_coord(),
				random_coord(), random_coord(), $urandom_range(0, 131071));
		else if (r < 23)
			send_request(ACT_NONE, $urandom_range(0, 63), $urandom, $urandom, $urandom,
				$urandom_range(0, 131071));
		else begin
			seg = ($urandom_range(0, 9) == 0 || n == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, n - 1);
			send_request((r < 62) ? hsev_pkg::ACT_POS : hsev_pkg::ACT_DER, seg, $urandom,
				$urandom, $urandom, random_t());
		end
	endtask

	// With no points in use every segment is out of range; nothing is read.
	task automatic test_empty_store;
		send_request(hsev_pkg::ACT_POS, 0, '0, '0, '0, 0);
		send_request(hsev_pkg::ACT_DER, 63, '1, '1, '1, 131071);
		send_request(ACT_NONE, 5, '0, '0, '0, 0);
	endtask

	task automatic test_fill_store;
		for (int i = 0; i < NPTS; i++)
			send_request(hsev_pkg::ACT_LOAD, i, random_coord(), random_coord(),
				random_coord(), 0);
	endtask

	task automatic test_directed;
		write_point_count(64);
		send_request(hsev_pkg::ACT_POS, 0, '0, '0, '0, 0);
		send_request(hsev_pkg::ACT_POS, 0, '0, '0, '0, 65536);
		send_request(hsev_pkg::ACT_DER, 31, '0, '0, '0, 32768);
		send_request(hsev_pkg::ACT_POS, 63, '0, '0, '0, 40000);
		send_request(hsev_pkg::ACT_DER, 63, '0, '0, '0, 131071);
		send_request(hsev_pkg::ACT_POS, 62, '0, '0, '0, 131071);
		// Alternating extremes drive the curve and its slope into saturation.
		for (int i = 10; i < 14; i++)
			send_request(hsev_pkg::ACT_LOAD, i, (i % 2) ? 32'h7fffffff : 32'h80000000,
				(i % 2) ? 32'h80000000 : 32'h7fffffff, 32'h7fffffff, 0);
		send_request(hsev_pkg::ACT_POS, 11, '0, '0, '0, 32768);
		send_request(hsev_pkg::ACT_DER, 11, '0, '0, '0, 0);
		send_request(hsev_pkg::ACT_DER, 12, '0, '0, '0, 65536);
		write_point_count(127);
		send_request(hsev_pkg::ACT_POS, 63, '0, '0, '0, 20000);
		write_point_count(3);
		send_request(hsev_pkg::ACT_POS, 2, '0, '0, '0, 30000);
		send_request(hsev_pkg::ACT_DER, 3, '0, '0, '0, 30000);
		write_point_count(1);
		send_request(hsev_pkg::ACT_DER, 0, '0, '0, '0, 1000);
	endtask

	task automatic test_random_phases;
		int counts [9] = '{0, 1, 2, 3, 4, 5, 63, 64, 100};
		int idle_set [4] = '{0, 53, 0, 31};
		int stall_set [4] = '{0, 0, 53, 31};
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 9; k++) begin
				write_point_count(counts[k]);
				send_idle_pct = idle_set[ph];
				recv_stall_pct = stall_set[ph];
				for (int i = 0; i < 30; i++)
					random_request(counts[k] > NPTS ? NPTS : counts[k]);
				send_idle_pct = 0;
			end
		end
		recv_stall_pct = 0;
	endtask

	// The receiver holds off while requests keep coming, so the block backs up.
	task automatic test_output_backpressure;
		write_point_count(64);
		hold_left = 400;
		for (int i = 0; i < 40; i++)
			send_request(($urandom_range(0, 1) ? hsev_pkg::ACT_POS : hsev_pkg::ACT_DER),
				$urandom_range(0, 63), '0, '0, '0, random_t());
		drain_all();
		for (int i = 0; i < 40; i++)
			random_request(64);
	endtask

	initial begin
		foreach (points[i, c])
			points[i][c] = 0;
		point_count_m = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_empty_store();
		test_fill_store();
		test_directed();
		test_random_phases();
		test_output_backpressure();
		drain_all();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
